// ----- hw/rtl/svd_pkg.sv -----
// svd_pkg: payload structs, register indexes and fixed constants for the
// stereo vibrato delay core. No dependencies.
package svd_pkg;

  typedef struct packed {
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
  } svd_in_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } svd_out_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 26;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY  = 2'd3;

  localparam logic [25:0] PHASE_STEP_RST  = 26'd178957;
  localparam logic [15:0] MOD_DEPTH_RST   = 16'd0;
  localparam logic [19:0] FADE_LENGTH_RST = 20'd4800;
  localparam logic [9:0]  BASE_DELAY_RST  = 10'd240;

  localparam logic [15:0] DEPTH_FULL  = 16'd32768;
  localparam logic [31:0] PHASE_QUART = 32'h4000_0000;

endpackage

// ----- hw/rtl/stereo_vibrato_delay_core.sv -----
// stereo_vibrato_delay_core: LFO-modulated fractional delay, stereo vibrato.
// A fade ramp computes its gain with a 16-step restoring divider, skipped once the
// ramp is done. One pair is processed at a time: the input stays stalled until
// the result beat leaves. Two channels of 8 sequencer steps each.
// Reset (rst, synchronous): config to reset values, phases to zero and a quarter
// turn, fade and write pointer cleared, then a pass zeroes the delay memory; no
// input taken then.
module stereo_vibrato_delay_core
  import svd_pkg::*;
#(
  parameter int unsigned DELAY_WORDS  = 2048,
  parameter int unsigned SINE_ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  svd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output svd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW   = $clog2(DELAY_WORDS);
  localparam int unsigned SW   = $clog2(SINE_ENTRIES);
  localparam int unsigned MAXB = (DELAY_WORDS - 4) / 2;
  localparam int unsigned DW   = AW + 16;  // delay position, Q.16
  // maximum delay in Q.16 stays below span, so one wrap add suffices

  // Quarter-wave sine: elaboration-time Taylor series, Q2.30, rounded to Q1.15.
  function automatic logic [16:0] sine_entry(input int unsigned k);
    logic [63:0] x, x2, term, sum, q;
    x = (64'd1686629713 * 64'(k)) / 64'(SINE_ENTRIES);
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    q = (sum + 64'd16384) >> 15;
    if (q > 64'd32768) q = 64'd32768;
    return q[16:0];
  endfunction

  logic [16:0] sine_rom [SINE_ENTRIES+1];
  always_comb begin
    for (int k = 0; k <= SINE_ENTRIES; k++) sine_rom[k] = sine_entry(k);
  end

  // config registers
  logic [25:0] phase_step;
  logic [15:0] mod_depth;
  logic [19:0] fade_length;
  logic [9:0]  base_delay;

  // sequencer
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_GAIN, S_DIV, S_EFF, S_CH_SIN, S_CH_MUL, S_CH_DLY,
    S_CH_WR, S_CH_RD0, S_CH_RD1, S_CH_MIX0, S_CH_MIX1, S_OUT
  } state_t;
  state_t state;

  logic [31:0]    phase [2];
  logic [AW-1:0]  write_pos;
  logic [19:0]    fade_left, fade_total;
  logic           depth_was_positive;
  logic [AW-1:0]  clr_addr;
  logic           ch;
  logic [4:0]     div_cnt;
  logic [36:0]    div_rem;
  logic [16:0]    gain;
  logic [15:0]    depth_sat;
  logic [9:0]     base_sat;
  logic [15:0]    eff;
  logic signed [17:0] lfo;
  logic signed [40:0] prod;   // shared multiplier result register
  logic [DW-1:0]  rpos;
  logic [23:0]    tap0;
  logic signed [23:0] result [2];
  svd_in_t        samp;

  // memory: one array per channel, single port used by the sequencer
  logic [23:0]    mem_l [DELAY_WORDS];
  logic [23:0]    mem_r [DELAY_WORDS];
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [23:0]    mem_wdata;
  logic [23:0]    mem_rdata_l, mem_rdata_r;
  logic           mem_wl, mem_wr;

  always_ff @(posedge clk) begin
    if (mem_we && mem_wl) mem_l[mem_addr] <= mem_wdata;
    if (mem_we && mem_wr) mem_r[mem_addr] <= mem_wdata;
    mem_rdata_l <= mem_l[mem_addr];
    mem_rdata_r <= mem_r[mem_addr];
  end

  logic [23:0] mem_rdata;
  assign mem_rdata = ch ? mem_rdata_r : mem_rdata_l;

  // sine lookup of the selected channel's (already advanced) phase
  logic [31:0]   ph_sel;
  logic [SW:0]   sidx;
  logic [16:0]   smag;
  assign ph_sel = phase[ch];
  always_comb begin
    sidx = {1'b0, ph_sel[29:30-SW]};
    if (ph_sel[30]) sidx = (SW+1)'(SINE_ENTRIES) - sidx;
    smag = sine_rom[sidx];
  end

  // shared multiplier: operands chosen by state, result registered
  // offset-binary taps are unsigned 24 bit, so operand A is 25 bit signed
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_EFF:     begin mul_a = 25'(depth_sat); mul_b = 18'(gain); end
      S_CH_MUL:  begin mul_a = 25'(signed'({1'b0, eff})); mul_b = lfo; end
      S_CH_DLY:  begin mul_a = 25'(base_sat); mul_b = '0; end
      S_CH_MIX0: begin mul_a = 25'(tap0); mul_b = 18'(17'h10000 - {1'b0, rpos[15:0]}); end
      S_CH_MIX1: begin mul_a = 25'(mem_rdata ^ 24'h800000); mul_b = 18'({2'b0, rpos[15:0]}); end
      default:   ;
    endcase
  end
  logic signed [41:0] mul_p;
  assign mul_p = 42'(mul_a) * 42'(mul_b);

  // delay: base * (2^30 + m) >> 14, m in prod; base <= 1022 so 41 bits fit
  logic [40:0] m_off;
  logic [50:0] dly_full;
  logic [DW-1:0] dly;
  assign m_off    = 41'(prod) + 41'h4000_0000;
  assign dly_full = 51'(m_off) * 51'(base_sat);
  assign dly      = DW'(dly_full >> 14);

  logic [DW:0] rp_sum;
  assign rp_sum = {1'b0, write_pos, 16'd0} - {1'b0, dly};

  // remainder doubles each step; it stays below 2*fade_total
  logic [36:0] div_shl;
  logic [36:0] div_try;
  assign div_shl = {div_rem[35:0], 1'b0};
  assign div_try = div_shl - {17'd0, fade_total};

  logic [40:0] acc;
  assign acc = 41'(prod) + 41'(mul_p);

  logic positive;
  assign positive = (mod_depth != 16'd0);

  assign in_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase_step <= PHASE_STEP_RST;
      mod_depth <= MOD_DEPTH_RST;
      fade_length <= FADE_LENGTH_RST;
      base_delay <= BASE_DELAY_RST;
      phase[0] <= '0;
      phase[1] <= PHASE_QUART;
      write_pos <= '0;
      fade_left <= '0;
      fade_total <= 20'd1;
      depth_was_positive <= 1'b0;
      clr_addr <= '0;
      out_valid <= 1'b0;
      ch <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PHASE_STEP:  phase_step <= cfg_data[25:0];
          REG_MOD_DEPTH:   mod_depth <= cfg_data[15:0];
          REG_FADE_LENGTH: fade_length <= cfg_data[19:0];
          REG_BASE_DELAY:  base_delay <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DELAY_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            samp <= in_data;
            depth_sat <= (mod_depth > DEPTH_FULL) ? DEPTH_FULL : mod_depth;
            base_sat <= (32'(base_delay) > MAXB) ? 10'(MAXB) : base_delay;
            depth_was_positive <= positive;
            if (!depth_was_positive && positive) begin
              fade_total <= (fade_length == 20'd0) ? 20'd1 : fade_length;
              fade_left  <= (fade_length == 20'd0) ? 20'd1 : fade_length;
            end
            phase[0] <= phase[0] + 32'(phase_step);
            phase[1] <= phase[1] + 32'(phase_step);
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (fade_left != 20'd0) begin
            div_rem <= 37'(fade_total - fade_left);
            div_cnt <= '0;
            gain <= '0;
            state <= S_DIV;
          end else begin
            gain <= (depth_sat != 16'd0) ? 17'h10000 : 17'd0;
            state <= S_EFF;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle (16 fraction bits)
          if (div_cnt == 5'd16) begin
            fade_left <= fade_left - 1'b1;
            state <= S_EFF;
          end else begin
            if (div_shl >= {17'd0, fade_total}) begin
              div_rem <= div_try;
              gain <= {gain[15:0], 1'b1};
            end else begin
              div_rem <= div_shl;
              gain <= {gain[15:0], 1'b0};
            end
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_EFF: begin
          eff <= 16'(mul_p >>> 16);
          ch <= 1'b0;
          state <= S_CH_SIN;
        end
        S_CH_SIN: begin
          lfo <= ph_sel[31] ? -18'(signed'({1'b0, smag})) : 18'(signed'({1'b0, smag}));
          state <= S_CH_MUL;
        end
        S_CH_MUL: begin
          prod <= 41'(mul_p);
          state <= S_CH_DLY;
        end
        S_CH_DLY: begin
          rpos <= DW'(rp_sum);
          state <= S_CH_WR;
        end
        S_CH_WR: state <= S_CH_RD0;
        S_CH_RD0: state <= S_CH_RD1;
        S_CH_RD1: begin
          tap0 <= mem_rdata ^ 24'h800000;
          state <= S_CH_MIX0;
        end
        S_CH_MIX0: begin
          prod <= 41'(mul_p);
          state <= S_CH_MIX1;
        end
        S_CH_MIX1: begin
          result[ch] <= (acc[39:16]) ^ 24'h800000;
          if (!ch) begin
            ch <= 1'b1;
            state <= S_CH_SIN;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_data.left_out <= result[0];
          out_data.right_out <= result[1];
          out_valid <= 1'b1;
          write_pos <= write_pos + 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // memory port steering: clear pass, sample write, then tap reads
  always_comb begin
    mem_we = 1'b0;
    mem_wl = 1'b0;
    mem_wr = 1'b0;
    mem_addr = write_pos;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1; mem_wl = 1'b1; mem_wr = 1'b1; mem_addr = clr_addr;
      end
      S_CH_WR: begin
        mem_we = 1'b1;
        mem_wl = !ch;
        mem_wr = ch;
        mem_wdata = ch ? samp.right_in : samp.left_in;
      end
      S_CH_RD0: mem_addr = rpos[DW-1:16];
      S_CH_RD1, S_CH_MIX0: mem_addr = rpos[DW-1:16] + 1'b1;
      default: ;
    endcase
  end

endmodule
